FILE: hdl/usbd_pkg.sv
// ----------------------------------------------------------------------------
// usbd_pkg
// Shared widths, defaults, result type and bit-reversal helper for the
// unanimous-sample byte debouncer.
// ----------------------------------------------------------------------------
package usbd_pkg;

    localparam int DATA_W              = 8;
    localparam int CHIP_W              = 2;
    localparam int DEFAULT_NUM_CHIPS   = 3;
    localparam int DEFAULT_NUM_SAMPLES = 4;

    typedef struct packed {
        logic [CHIP_W-1:0] chip;
        logic [DATA_W-1:0] bits;
    } t_result;

    // Reverse bit order: bit 0 <-> bit 7, and so on.
    function automatic logic [DATA_W-1:0] flip_byte(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] y;
        for (int i = 0; i < DATA_W; i++) begin
            y[i] = v[DATA_W-1-i];
        end
        return y;
    endfunction

endpackage

FILE: hdl/usbd_ram.sv
// ----------------------------------------------------------------------------
// usbd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read of an address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module usbd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/unanimous_sample_byte_debouncer.sv
// ----------------------------------------------------------------------------
// unanimous_sample_byte_debouncer
// Debounces one raw byte per input chip against that chip's ring of recent
// samples; a bit changes only when every stored sample agrees.
// ----------------------------------------------------------------------------
// Path: an accepted transaction launches the RAM read and is registered into the
//   update stage, which votes, writes the row and pushes the stall-absorbing queue.
// Throughput: one transaction per cycle while the two-entry output queue has room;
//   the single read-modify-write pass through the per-chip row memory sets it.
// Reset (i_rst_n low, synchronous): clears row valid bits, sample head,
//   reverse_bits, pipeline and output queue. Rows read as zero until written.
// ----------------------------------------------------------------------------
module unanimous_sample_byte_debouncer
    import usbd_pkg::*;
#(
    parameter int NUM_CHIPS   = DEFAULT_NUM_CHIPS,
    parameter int NUM_SAMPLES = DEFAULT_NUM_SAMPLES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // configuration: reverse_bits
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,

    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [7:0] raw_byte
    input  logic [CHIP_W-1:0] s_tuser,   // [1:0] chip_index
    input  logic              s_tlast,   // end_of_scan

    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [7:0] debounced_byte
    output logic [CHIP_W-1:0] m_tuser    // [1:0] chip_echo
);

    // Each memory row holds one chip: its samples in the low bytes (slot s at
    // byte s) and its current debounced byte on top.
    localparam int SAMP_W  = DATA_W * NUM_SAMPLES;
    localparam int ROW_W   = SAMP_W + DATA_W;
    localparam int ADDR_W  = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
    localparam int VALID_N = 1 << ADDR_W;
    localparam int HEAD_W  = $clog2(NUM_SAMPLES);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic r_reverse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse <= 1'b0;
        end else if (i_cfg_we) begin
            r_reverse <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and flow control
    // ------------------------------------------------------------------
    logic       w_in_fire;
    logic       w_out_fire;
    logic [1:0] w_busy;
    logic       r_s1_valid;
    logic [1:0] r_q_count;

    assign w_in_fire  = s_tvalid & s_tready;
    assign w_out_fire = m_tvalid & m_tready;

    // Every item in the update stage lands in the queue on the next edge, so
    // accept only while the queue plus the update stage leaves one free slot.
    assign w_busy   = {1'b0, r_s1_valid} + r_q_count - {1'b0, w_out_fire};
    assign s_tready = (w_busy < 2'd2);

    // ------------------------------------------------------------------
    // Accept stage: launch the row read, capture the item, advance the head
    // ------------------------------------------------------------------
    logic [HEAD_W-1:0] r_head;
    logic [HEAD_W-1:0] n_head;
    logic [HEAD_W-1:0] r_s1_head;
    logic [CHIP_W-1:0] r_s1_chip;
    logic [DATA_W-1:0] r_s1_raw;

    always_comb begin
        n_head = r_head;
        if (w_in_fire && s_tlast) begin
            // wrap from the last slot back to zero
            if (r_head == HEAD_W'(NUM_SAMPLES - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_s1_valid <= w_in_fire;
        end
    end

    // Payload of the update stage; the head seen here is the one before this
    // item's own end-of-scan advance.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_head <= r_head;
            r_s1_chip <= s_tuser;
            r_s1_raw  <= r_reverse ? flip_byte(s_tdata) : s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Row memory
    // ------------------------------------------------------------------
    logic              w_we;
    logic [ADDR_W-1:0] w_s1_addr;
    logic [ROW_W-1:0]  w_new_row;
    logic [ROW_W-1:0]  w_rd_row;

    usbd_ram #(
        .WIDTH  (ROW_W),
        .DEPTH  (NUM_CHIPS),
        .ADDR_W (ADDR_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_s1_addr),
        .i_wdata (w_new_row),
        .i_re    (w_in_fire),
        .i_raddr (ADDR_W'(s_tuser)),
        .o_rdata (w_rd_row)
    );

    // ------------------------------------------------------------------
    // Update stage: pick the current row, insert the sample, vote
    // ------------------------------------------------------------------
    logic [VALID_N-1:0] r_row_valid;
    logic               r_fwd_valid;
    logic [ADDR_W-1:0]  r_fwd_addr;
    logic [ROW_W-1:0]   r_fwd_row;
    logic               w_in_range;
    logic [ROW_W-1:0]   w_old_row;
    logic [DATA_W-1:0]  w_all_high;
    logic [DATA_W-1:0]  w_all_low;
    logic [DATA_W-1:0]  w_stable;
    logic [DATA_W-1:0]  w_result;

    assign w_s1_addr  = ADDR_W'(r_s1_chip);
    assign w_in_range = (int'(r_s1_chip) < NUM_CHIPS);
    assign w_we       = r_s1_valid & w_in_range;

    always_comb begin
        // The item just before this one wrote its row on the same edge this
        // item read it, so the RAM returned stale data: forward the new row.
        if (r_fwd_valid && (r_fwd_addr == w_s1_addr)) begin
            w_old_row = r_fwd_row;
        end else if (r_row_valid[w_s1_addr]) begin
            w_old_row = w_rd_row;
        end else begin
            w_old_row = '0;
        end

        w_new_row  = w_old_row;
        w_all_high = '1;
        w_all_low  = '1;
        for (int s = 0; s < NUM_SAMPLES; s++) begin
            if (r_s1_head == HEAD_W'(s)) begin
                w_new_row[s*DATA_W +: DATA_W] = r_s1_raw;
            end
            w_all_high = w_all_high & w_new_row[s*DATA_W +: DATA_W];
            w_all_low  = w_all_low & ~w_new_row[s*DATA_W +: DATA_W];
        end

        // hold bits where samples disagree, follow them where unanimous
        w_stable = w_old_row[SAMP_W +: DATA_W];
        w_result = (w_stable & ~(w_all_high | w_all_low)) | w_all_high;
        w_new_row[SAMP_W +: DATA_W] = w_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= w_we;
            if (w_we) begin
                r_row_valid[w_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_fwd_addr <= w_s1_addr;
            r_fwd_row  <= w_new_row;
        end
    end

    // ------------------------------------------------------------------
    // Output queue: two entries, so input keeps flowing while a result waits
    // ------------------------------------------------------------------
    t_result r_q_item [2];
    t_result w_push_item;
    logic    r_q_wr;
    logic    r_q_rd;

    assign w_push_item.chip = r_s1_chip;
    assign w_push_item.bits = w_in_range ? w_result : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= 1'b0;
            r_q_rd    <= 1'b0;
            r_q_count <= '0;
        end else begin
            if (r_s1_valid) begin
                r_q_wr <= ~r_q_wr;
            end
            if (w_out_fire) begin
                r_q_rd <= ~r_q_rd;
            end
            r_q_count <= r_q_count + {1'b0, r_s1_valid} - {1'b0, w_out_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_q_item[r_q_wr] <= w_push_item;
        end
    end

    assign m_tvalid = (r_q_count != 2'd0);
    assign m_tdata  = r_q_item[r_q_rd].bits;
    assign m_tuser  = r_q_item[r_q_rd].chip;

endmodule

FILE: tb/sv/unanimous_sample_byte_debouncer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unanimous_sample_byte_debouncer_tb
// Self-checking bench for the unanimous-sample byte debouncer. Drives raw
// chip bytes as stream transactions, keeps its own copy of the sample rings
// and debounced bytes, and compares every result against that copy. Covers
// extreme bytes, absent chips, head wrap, bit reversal, back-pressure that
// fills the output queue, and long runs of bouncing switch scans.
// ----------------------------------------------------------------------------
module unanimous_sample_byte_debouncer_tb;
    import usbd_pkg::*;

    localparam int N_CHIPS    = DEFAULT_NUM_CHIPS;
    localparam int N_SAMPLES  = DEFAULT_NUM_SAMPLES;
    localparam int SETTLE_CYC = 6;      // pipeline is two deep, allow margin
    localparam int SCAN_ITEMS = 430;    // items per random scan phase

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // [7:0] raw_byte
    logic [CHIP_W-1:0] s_tuser;   // [1:0] chip_index
    logic              s_tlast;   // end_of_scan
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // [7:0] debounced_byte
    logic [CHIP_W-1:0] m_tuser;   // [1:0] chip_echo

    unanimous_sample_byte_debouncer #(
        .NUM_CHIPS   (N_CHIPS),
        .NUM_SAMPLES (N_SAMPLES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Predictor state: sample rings, debounced bytes, shared head, reversal
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] ring_bytes [N_CHIPS][N_SAMPLES];
    logic [DATA_W-1:0] debounced_now [N_CHIPS];
    int                ring_head;
    logic              reverse_on;

    t_result pending_debounced_q [$];

    // Stimulus model of the switches: level per chip and remaining bounce
    logic [DATA_W-1:0] pin_level [N_CHIPS];
    int                bounce_left [N_CHIPS];

    // Idling control shared by sender and receiver
    bit no_idle_stretch;
    int sink_hold_req;
    int sink_hold_left;
    int sink_stall_left;

    // Bookkeeping
    int mismatch_count;
    int samples_sent;
    int absent_chip_sent;
    int results_checked;
    int reverse_phases;
    t_result got_want;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Stop here if handshakes hang; the worst-case run ends well before this limit.
    initial begin
        #10_000_000;
        $display("unanimous_sample_byte_debouncer verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Report one mismatch: print one line and count it
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Predictor: store the byte, vote across the ring, advance the head
    // ------------------------------------------------------------------------
    function automatic t_result debounce_predict(input logic [CHIP_W-1:0] chip,
                                                 input logic [DATA_W-1:0] raw,
                                                 input logic              eos);
        t_result           res;
        logic [DATA_W-1:0] stored;
        logic [DATA_W-1:0] all_one;
        logic [DATA_W-1:0] all_zero;
        if (reverse_on) begin
            stored = {<<{raw}};
        end else begin
            stored = raw;
        end
        res.chip = chip;
        res.bits = '0;
        // Absent chips store nothing and answer zero.
        if (int'(chip) < N_CHIPS) begin
            ring_bytes[chip][ring_head] = stored;
            all_one  = '1;
            all_zero = '1;
            for (int s = 0; s < N_SAMPLES; s++) begin
                all_one  &= ring_bytes[chip][s];
                all_zero &= ~ring_bytes[chip][s];
            end
            // Unanimous bits take the vote, split bits hold their old value.
            debounced_now[chip] = (debounced_now[chip] & ~(all_one | all_zero)) | all_one;
            res.bits = debounced_now[chip];
        end
        if (eos) begin
            ring_head = (ring_head + 1) % N_SAMPLES;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one transaction, gap first, hold until accepted
    // ------------------------------------------------------------------------
    function automatic int pick_send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle_stretch) return 0;
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic send_scan_item(input logic [CHIP_W-1:0] chip,
                                  input logic [DATA_W-1:0] raw,
                                  input logic              eos);
        int gap;
        gap = pick_send_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // Keep tvalid high straight into the next item when there is no gap.
        s_tvalid = 1'b1;
        s_tuser  = chip;
        s_tdata  = raw;
        s_tlast  = eos;
        do @(posedge i_clk); while (!s_tready);
        pending_debounced_q.push_back(debounce_predict(chip, raw, eos));
        samples_sent++;
        if (int'(chip) >= N_CHIPS) absent_chip_sent++;
    endtask

    // Drop tvalid and wait until every expected result has come back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_debounced_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write reverse_bits while the block is idle.
    task automatic write_reverse_bits(input logic value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        reverse_on  = value;
        if (value) reverse_phases++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, long hold-offs on request, quiet stretches
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        int r;
        if (sink_hold_req != 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
        end
        if (sink_hold_left != 0) begin
            m_tready = 1'b0;
            sink_hold_left--;
        end else if (no_idle_stretch) begin
            m_tready = 1'b1;
        end else if (sink_stall_left != 0) begin
            m_tready = 1'b0;
            sink_stall_left--;
        end else begin
            m_tready = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 20) begin
                sink_stall_left = $urandom_range(1, 3);
            end else if (r < 23) begin
                sink_stall_left = $urandom_range(10, 30);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_debounced_q.size() == 0) begin
                report_mismatch("result with nothing expected", int'(m_tdata), 0);
            end else begin
                got_want = pending_debounced_q.pop_front();
                if (m_tuser !== got_want.chip) begin
                    report_mismatch("chip_echo", int'(m_tuser), int'(got_want.chip));
                end
                if (m_tdata !== got_want.bits) begin
                    report_mismatch("debounced_byte", int'(m_tdata), int'(got_want.bits));
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Switch model for scans: settle, flip a pin now and then, bounce after
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] next_pin_byte(input int chip);
        logic [DATA_W-1:0] raw;
        if (bounce_left[chip] == 0) begin
            case ($urandom_range(0, 23))
                0, 1: begin
                    pin_level[chip]   = pin_level[chip] ^ (8'h01 << $urandom_range(0, 7));
                    bounce_left[chip] = $urandom_range(1, 5);
                end
                2: begin
                    // Every pin moves at once, toward all high or all low.
                    pin_level[chip]   = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                    bounce_left[chip] = $urandom_range(0, 3);
                end
                default: ;
            endcase
        end
        raw = pin_level[chip];
        if (bounce_left[chip] != 0) begin
            raw = raw ^ DATA_W'($urandom & $urandom);
            bounce_left[chip]--;
        end
        return raw;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fill every ring slot with the extremes, then break unanimity.
    task automatic test_reset_extremes();
        write_reverse_bits(1'b0);
        for (int s = 0; s < N_SAMPLES; s++) begin
            send_scan_item(2'd0, 8'hFF, 1'b0);
            send_scan_item(2'd1, 8'h00, 1'b0);
            send_scan_item(2'd2, (s % 2 == 0) ? 8'hA5 : 8'h5A, 1'b1);
        end
        // One low sample must not clear the all-high byte.
        send_scan_item(2'd0, 8'h00, 1'b0);
        wait_results_drained();
    endtask

    // Absent chip: answers zero and still advances the head.
    task automatic test_absent_chip();
        send_scan_item(2'd3, 8'hFF, 1'b1);
        send_scan_item(2'd3, 8'h00, 1'b0);
        send_scan_item(2'd0, 8'h7E, 1'b1);
        wait_results_drained();
    endtask

    // Reversal: a single low bit walks to the top once all slots agree.
    task automatic test_bit_reverse();
        write_reverse_bits(1'b1);
        for (int s = 0; s < N_SAMPLES; s++) begin
            send_scan_item(2'd1, 8'h01, 1'b1);
        end
        send_scan_item(2'd2, 8'h0F, 1'b0);
        wait_results_drained();
    endtask

    // Hold the receiver off long enough that the input side must stall.
    task automatic test_backpressure_fill();
        no_idle_stretch = 1'b0;
        sink_hold_req   = 80;
        for (int k = 0; k < 40; k++) begin
            send_scan_item(CHIP_W'($urandom_range(0, 3)), DATA_W'($urandom),
                           1'($urandom_range(0, 1)));
        end
        wait_results_drained();
    endtask

    // Bouncing scans with some noise; pause the sender now and then.
    task automatic test_random_scans(input logic reverse_value);
        int phase_sent;
        write_reverse_bits(reverse_value);
        phase_sent = 0;
        while (phase_sent < SCAN_ITEMS) begin
            if (phase_sent % 100 < 3) begin
                no_idle_stretch = ($urandom_range(0, 3) == 0);
            end
            if (phase_sent % 200 < 3 && phase_sent != 0) begin
                wait_results_drained();
            end
            if ($urandom_range(0, 99) < 85) begin
                for (int c = 0; c < N_CHIPS; c++) begin
                    send_scan_item(CHIP_W'(c), next_pin_byte(c), c == N_CHIPS - 1);
                end
                phase_sent += N_CHIPS;
            end else begin
                send_scan_item(CHIP_W'($urandom_range(0, 3)), DATA_W'($urandom),
                               1'($urandom_range(0, 1)));
                phase_sent++;
            end
        end
        no_idle_stretch = 1'b0;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        no_idle_stretch = 1'b0;
        sink_hold_req   = 0;
        sink_hold_left  = 0;
        sink_stall_left = 0;
        mismatch_count  = 0;
        samples_sent    = 0;
        absent_chip_sent = 0;
        results_checked = 0;
        reverse_phases  = 0;
        ring_head       = 0;
        reverse_on      = 1'b0;
        for (int c = 0; c < N_CHIPS; c++) begin
            debounced_now[c] = '0;
            pin_level[c]     = '0;
            bounce_left[c]   = 0;
            for (int s = 0; s < N_SAMPLES; s++) ring_bytes[c][s] = '0;
        end

        // Hold reset, then release it on a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_extremes();
        test_absent_chip();
        test_bit_reverse();
        test_backpressure_fill();
        test_random_scans(1'b0);
        test_random_scans(1'b1);
        test_random_scans(1'b0);
        test_random_scans(1'b1);

        wait_results_drained();
        if (pending_debounced_q.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_debounced_q.size());
        end

        $display("Covered %0d transactions (%0d to absent chips), %0d results checked,",
                 samples_sent, absent_chip_sent, results_checked);
        $display("  reversal on in %0d phases, back-pressure fill and sender pauses.",
                 reverse_phases);
        if (mismatch_count == 0) begin
            $display("unanimous_sample_byte_debouncer verification clean");
        end else begin
            $display("unanimous_sample_byte_debouncer verification failed");
        end
        $finish;
    end

endmodule
